### src/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants and types for the falling-sand block automaton.
// ----------------------------------------------------------------------------
package msa_pkg;

	localparam int GRID_WIDTH  = 300;
	localparam int GRID_HEIGHT = 1000;
	localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW          = $clog2(CELLS);
	localparam int CW          = $clog2(GRID_WIDTH + 1);
	localparam int RW          = $clog2(GRID_HEIGHT + 1);

	localparam logic [31:0] LFSR_MASK = 32'hA300_0000;

	localparam logic [1:0] CELL_EMPTY  = 2'd0;
	localparam logic [1:0] CELL_SAND   = 2'd1;
	localparam logic [1:0] CELL_BORDER = 2'd2;

	localparam logic [1:0] ACT_INIT  = 2'd0;
	localparam logic [1:0] ACT_PASS  = 2'd1;
	localparam logic [1:0] ACT_ERASE = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [1:0] REG_BORDER = 2'd0;
	localparam logic [1:0] REG_TAPER  = 2'd1;
	localparam logic [1:0] REG_SEED   = 2'd2;

	typedef logic [AW-1:0] addr_t;
	typedef logic [1:0]    cell_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_en;
		addr_t wr_addr;
		cell_t wr_data;
	} mem_req_t;

endpackage

### src/msa_grid_ram.sv
// ----------------------------------------------------------------------------
// msa_grid_ram
// Grid memory with one read and one write port, registered read.
// ----------------------------------------------------------------------------
module msa_grid_ram
	import msa_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output cell_t    rd_data
);

	cell_t mem [CELLS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

### src/margolus_sand_automaton.sv
// ----------------------------------------------------------------------------
// margolus_sand_automaton
// Hourglass falling-sand automaton; grid held in one memory (one read, one write port).
//
//  channel | handshake           | payload
//  cmd     | start / busy        | action, col_pos, row_pos, radius
//  result  | done (one cycle)    | cell_value
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Init: one write per cell. Pass: 4 reads and 4 writes per 2x2 block.
// Erase: a read per cell of the bounding box, and a write that empties each
// sand cell inside the disk. Read: one read. done follows the last busy cycle.
// Reset clears control and phase, sets LFSR and config to defaults; the grid is undefined until init.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module margolus_sand_automaton
	import msa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [8:0]  col_pos,
	input  logic [9:0]  row_pos,
	input  logic [9:0]  radius,
	output logic        done,
	output logic [1:0]  cell_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_PRD, S_PWAIT, S_PWR, S_ERD, S_EWR, S_RRD, S_RWAIT, S_DONE
	} state_t;

	state_t state_q;
	logic [6:0]  border_q, taper_q;
	logic [31:0] seed_q, lfsr_q;
	logic        phase_q;
	logic [RW-1:0] r_q, rmax_q;
	logic [CW-1:0] c_q, cmin_q, cmax_q;
	logic [CW-1:0] off_q;
	logic [6:0]    tcnt_q;
	logic [1:0]    k_q;
	cell_t         blk_q [4];
	logic [1:0]    val_q;
	logic signed [11:0] x_q, y_q;
	logic [20:0]   r2_q;
	logic          hit_q;
	mem_req_t      req;
	cell_t         rd_data;

	msa_grid_ram u_ram (.clk(clk), .req(req), .rd_data(rd_data));

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// block cell address
	logic [RW-1:0] br;
	logic [CW-1:0] bc;
	always_comb begin
		br = r_q + RW'(k_q[1]);
		bc = c_q + CW'(k_q[0]);
	end
	addr_t baddr;
	assign baddr = AW'(br) * AW'(GRID_WIDTH) + AW'(bc);
	addr_t caddr;
	assign caddr = AW'(r_q) * AW'(GRID_WIDTH) + AW'(c_q);

	// rules
	cell_t na, nb, nc, nd;
	logic  adv;
	always_comb begin
		logic as_, bs_, cs_, ds_, ce_, de_;
		as_ = blk_q[0] == CELL_SAND; bs_ = blk_q[1] == CELL_SAND;
		cs_ = blk_q[2] == CELL_SAND; ds_ = blk_q[3] == CELL_SAND;
		ce_ = blk_q[2] == CELL_EMPTY; de_ = blk_q[3] == CELL_EMPTY;
		na = blk_q[0]; nb = blk_q[1]; nc = blk_q[2]; nd = blk_q[3];
		adv = 1'b0;
		if (as_ && bs_ && ce_ && de_) begin
			adv = 1'b1;
			if (lfsr_q[0]) begin
				na = CELL_EMPTY; nb = CELL_EMPTY; nc = CELL_SAND; nd = CELL_SAND;
			end
		end else if (as_ && bs_ && ce_ && ds_) begin na = CELL_EMPTY; nc = CELL_SAND; end
		else if (as_ && bs_ && cs_ && de_) begin nb = CELL_EMPTY; nd = CELL_SAND; end
		else if (as_ && !bs_ && ce_ && ds_) begin na = CELL_EMPTY; nc = CELL_SAND; end
		else if (!as_ && bs_ && cs_ && de_) begin nb = CELL_EMPTY; nd = CELL_SAND; end
		else if (as_ && !bs_ && !ce_ && de_) begin na = CELL_EMPTY; nd = CELL_SAND; end
		else if (!as_ && bs_ && ce_ && !de_) begin nb = CELL_EMPTY; nc = CELL_SAND; end
		else if (as_ && !bs_ && ce_ && !ds_) begin na = CELL_EMPTY; nc = CELL_SAND; end
		else if (!as_ && bs_ && !cs_ && de_) begin nb = CELL_EMPTY; nd = CELL_SAND; end
	end
	cell_t wsel;
	always_comb begin
		case (k_q)
			2'd0:    wsel = na;
			2'd1:    wsel = nb;
			2'd2:    wsel = nc;
			default: wsel = nd;
		endcase
	end

	// init cell value
	cell_t ival;
	always_comb begin
		if ((c_q < off_q) || (11'(c_q) + 11'(off_q) >= 11'(GRID_WIDTH))
			|| (r_q < RW'(border_q)) || (13'(r_q) + 13'(border_q) >= 13'(GRID_HEIGHT)))
			ival = CELL_BORDER;
		else if (r_q < RW'(GRID_HEIGHT / 2))
			ival = CELL_SAND;
		else
			ival = CELL_EMPTY;
	end

	// erase disk distance, dx^2+dy^2 at 24 bits
	logic signed [11:0] dx, dy;
	logic signed [23:0] dxw, dyw;
	logic [23:0] d2;
	assign dx = x_q - $signed({1'b0, 11'(c_q)});
	assign dy = y_q - $signed({1'b0, 11'(r_q)});
	assign dxw = 24'(dx);
	assign dyw = 24'(dy);
	assign d2 = $unsigned(dxw * dxw + dyw * dyw);

	always_comb begin
		req = '0;
		case (state_q)
			S_INIT: begin
				req.wr_en = 1'b1; req.wr_addr = caddr; req.wr_data = ival;
			end
			S_PRD: begin
				req.rd_en = 1'b1; req.rd_addr = baddr;
			end
			S_PWR: begin
				req.wr_en = 1'b1; req.wr_addr = baddr; req.wr_data = wsel;
			end
			S_ERD, S_RRD: begin
				req.rd_en = 1'b1; req.rd_addr = caddr;
			end
			S_EWR: begin
				req.wr_en = hit_q && (rd_data == CELL_SAND);
				req.wr_addr = caddr; req.wr_data = CELL_EMPTY;
			end
			default: ;
		endcase
	end

	logic [RW-1:0] pr_max;
	logic [CW-1:0] pc_max;
	assign pr_max = RW'(2 * (GRID_HEIGHT / 2 - 1));
	assign pc_max = CW'(2 * (GRID_WIDTH / 2 - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			border_q <= 7'd3; taper_q <= 7'd4; seed_q <= 32'd1; lfsr_q <= 32'd1;
			phase_q <= 1'b0; done <= 1'b0; cell_value <= CELL_EMPTY;
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_BORDER: border_q <= cfg_data[6:0];
					REG_TAPER:  taper_q <= cfg_data[6:0];
					REG_SEED:   seed_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (start) begin
					val_q <= CELL_EMPTY;
					r_q <= '0; c_q <= '0; k_q <= '0;
					case (action)
						ACT_INIT: begin
							off_q <= '0; tcnt_q <= '0; state_q <= S_INIT;
						end
						ACT_PASS: begin
							r_q <= RW'(phase_q); c_q <= CW'(phase_q);
							state_q <= S_PRD;
						end
						ACT_ERASE: begin
							x_q <= 12'(col_pos); y_q <= 12'(row_pos);
							r2_q <= 21'(radius) * 21'(radius);
							if ((col_pos > 9'(GRID_WIDTH)) || (row_pos > 10'(GRID_HEIGHT)))
								state_q <= S_DONE;
							else begin
								cmin_q <= (col_pos > 9'(radius)) && (radius < 10'd512)
									? CW'(col_pos - 9'(radius)) : '0;
								c_q <= (col_pos > 9'(radius)) && (radius < 10'd512)
									? CW'(col_pos - 9'(radius)) : '0;
								r_q <= (row_pos > radius) ? RW'(row_pos - radius) : '0;
								cmax_q <= (11'(col_pos) + 11'(radius) > 11'(GRID_WIDTH - 2))
									? CW'(GRID_WIDTH - 2) : CW'(11'(col_pos) + 11'(radius));
								rmax_q <= (11'(row_pos) + 11'(radius) > 11'(GRID_HEIGHT - 2))
									? RW'(GRID_HEIGHT - 2) : RW'(11'(row_pos) + 11'(radius));
								state_q <= S_ERD;
							end
						end
						default: begin
							r_q <= RW'(row_pos); c_q <= CW'(col_pos);
							if (col_pos < 9'(GRID_WIDTH) && row_pos < 10'(GRID_HEIGHT))
								state_q <= S_RRD;
							else
								state_q <= S_DONE;
						end
					endcase
				end
				S_INIT: begin
					if (c_q == CW'(GRID_WIDTH - 1)) begin
						c_q <= '0;
						if (tcnt_q == 7'd0) begin
							if (r_q < RW'(GRID_HEIGHT / 2)) off_q <= off_q + 1'b1;
							else if (off_q != '0) off_q <= off_q - 1'b1;
						end
						tcnt_q <= (tcnt_q + 7'd1 >= ((taper_q == 7'd0) ? 7'd1 : taper_q))
							? 7'd0 : tcnt_q + 7'd1;
						if (r_q == RW'(GRID_HEIGHT - 1)) begin
							lfsr_q <= (seed_q == 32'd0) ? 32'd1 : seed_q;
							state_q <= S_DONE;
						end else r_q <= r_q + 1'b1;
					end else c_q <= c_q + 1'b1;
				end
				S_PRD: begin
					state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					blk_q[k_q] <= rd_data;
					k_q <= k_q + 1'b1;
					state_q <= (k_q == 2'd3) ? S_PWR : S_PRD;
				end
				S_PWR: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						if (adv) lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : 32'd0);
						if (c_q + CW'(2) > pc_max) begin
							c_q <= CW'(phase_q);
							if (r_q + RW'(2) > pr_max) begin
								phase_q <= ~phase_q;
								state_q <= S_DONE;
							end else begin
								r_q <= r_q + RW'(2); state_q <= S_PRD;
							end
						end else begin
							c_q <= c_q + CW'(2); state_q <= S_PRD;
						end
					end
				end
				S_ERD: begin
					hit_q <= ({3'b0, d2[20:0]} == d2) && (d2[20:0] < r2_q);
					if (r_q >= rmax_q || cmin_q >= cmax_q) state_q <= S_DONE;
					else state_q <= S_EWR;
				end
				S_EWR: begin
					if (c_q + 1'b1 >= cmax_q) begin
						c_q <= cmin_q;
						r_q <= r_q + 1'b1;
					end else c_q <= c_q + 1'b1;
					state_q <= S_ERD;
				end
				S_RRD: state_q <= S_RWAIT;
				S_RWAIT: begin
					val_q <= rd_data; state_q <= S_DONE;
				end
				default: begin
					done <= 1'b1; cell_value <= val_q; state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
